// ===== rtl/scov_pkg.sv =====
// ----------------------------------------------------------------------------
// scov_pkg
// Shared types and constants of the splat covariance pipeline.
// ----------------------------------------------------------------------------
package scov_pkg;

    localparam int SCALE_FRAC_BITS = 20;
    localparam int COV_FRAC_BITS   = 32;

    localparam int ROT_W   = 8;
    localparam int SCALE_W = 24;
    localparam int SQ_W    = 2 * SCALE_W;
    localparam int HALF_W  = SCALE_W;
    localparam int PROD_W  = 16;
    localparam int MAT_W   = 17;
    localparam int P_W     = 32;
    localparam int PP_W    = 56;
    localparam int ACC_W   = 58;
    localparam int TOT_W   = 82;
    localparam int COV_W   = 48;

    localparam int N_MAT = 9;
    localparam int N_ROW = 3;
    localparam int N_ENT = 6;

    localparam int IN_W  = 4 * ROT_W + 3 * SCALE_W;
    localparam int OUT_W = N_ENT * COV_W;

    // product shift from q13 * q13 * scale^2 down to the output fraction
    localparam int SHIFT = 26 + 2 * SCALE_FRAC_BITS - COV_FRAC_BITS;

    localparam logic signed [MAT_W-1:0] ONE_Q13 = MAT_W'(8192);

    // row and column of each unique covariance entry
    localparam int ENT_I [N_ENT] = '{0, 0, 0, 1, 1, 2};
    localparam int ENT_J [N_ENT] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [SCALE_W-1:0] scale_c;
        logic [SCALE_W-1:0] scale_b;
        logic [SCALE_W-1:0] scale_a;
        logic [ROT_W-1:0]   rot_z;
        logic [ROT_W-1:0]   rot_y;
        logic [ROT_W-1:0]   rot_x;
        logic [ROT_W-1:0]   rot_w;
    } in_word_t;

    typedef logic signed [MAT_W-1:0] mat_t   [N_MAT];
    typedef logic        [SQ_W-1:0]  sq_t    [N_ROW];
    typedef logic signed [ACC_W-1:0] acc_t   [N_ENT];
    typedef logic signed [COV_W-1:0] cov_t   [N_ENT];

endpackage

// ===== rtl/splat_covariance_from_rotation_scale_core.sv =====
// ----------------------------------------------------------------------------
// splat_covariance_from_rotation_scale_core
// Covariance of a 3d gaussian splat from a byte quaternion and three scales.
// ----------------------------------------------------------------------------
// The core takes one splat word per clock and returns one covariance word per
// splat, in order. Throughput is one word per cycle while the output is not
// stalled; its stages are the quaternion products and scale squares, the
// rotation matrix, the matrix entry products, the products against the split
// scale squares, the row sums, the join of high and low sums and the final shift
// and saturate. An output stall freezes all of it; a one-word skid register
// keeps s_axis_tready registered; a word held by a stall drops it next cycle.
module splat_covariance_from_rotation_scale_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // rot_w, rot_x, rot_y, rot_z, scale_a, scale_b, scale_c
    input  logic [scov_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // cov_00, cov_01, cov_02, cov_11, cov_12, cov_22
    output logic [scov_pkg::OUT_W-1:0] m_axis_tdata
);
    import scov_pkg::*;

    logic     adv;
    logic     skid_valid;
    in_word_t skid_data;
    logic     rot_valid;
    mat_t     m;
    sq_t      sq;
    logic     mac_valid;
    acc_t     acc_hi;
    acc_t     acc_lo;
    logic     out_valid;
    cov_t     cov;

    assign adv = !out_valid || m_axis_tready;

    scov_skid u_skid (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (in_word_t'(s_axis_tdata)),
        .adv     (adv),
        .valid   (skid_valid),
        .data    (skid_data)
    );

    scov_rot u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (skid_valid),
        .in_data  (skid_data),
        .valid    (rot_valid),
        .m        (m),
        .sq       (sq)
    );

    scov_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (rot_valid),
        .m        (m),
        .sq       (sq),
        .valid    (mac_valid),
        .acc_hi   (acc_hi),
        .acc_lo   (acc_lo)
    );

    scov_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (mac_valid),
        .acc_hi   (acc_hi),
        .acc_lo   (acc_lo),
        .valid    (out_valid),
        .cov      (cov)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {cov[5], cov[4], cov[3], cov[2], cov[1], cov[0]};

endmodule

// ===== rtl/scov_skid.sv =====
// ----------------------------------------------------------------------------
// scov_skid
// Input skid register; holds one word while the pipeline is stalled.
// ----------------------------------------------------------------------------
module scov_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  scov_pkg::in_word_t s_data,
    input  logic               adv,
    output logic               valid,
    output scov_pkg::in_word_t data
);
    import scov_pkg::*;

    logic     skid_valid_reg;
    logic     skid_valid_next;
    in_word_t skid_data_reg;

    assign s_ready = !skid_valid_reg;
    assign valid   = skid_valid_reg || s_valid;
    assign data    = skid_valid_reg ? skid_data_reg : s_data;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else if (s_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_data_reg <= s_data;
        end
    end

endmodule

// ===== rtl/scov_rot.sv =====
// ----------------------------------------------------------------------------
// scov_rot
// Two stages: quaternion products and scale squares, then the q13 rotation
// matrix.
// ----------------------------------------------------------------------------
module scov_rot (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  scov_pkg::in_word_t in_data,
    output logic               valid,
    output scov_pkg::mat_t     m,
    output scov_pkg::sq_t      sq
);
    import scov_pkg::*;

    logic signed [ROT_W-1:0]  cw;
    logic signed [ROT_W-1:0]  cx;
    logic signed [ROT_W-1:0]  cy;
    logic signed [ROT_W-1:0]  cz;

    logic signed [PROD_W-1:0] xx_reg;
    logic signed [PROD_W-1:0] yy_reg;
    logic signed [PROD_W-1:0] zz_reg;
    logic signed [PROD_W-1:0] xy_reg;
    logic signed [PROD_W-1:0] xz_reg;
    logic signed [PROD_W-1:0] yz_reg;
    logic signed [PROD_W-1:0] wx_reg;
    logic signed [PROD_W-1:0] wy_reg;
    logic signed [PROD_W-1:0] wz_reg;
    sq_t                      sq1_reg;
    logic                     valid1_reg;

    mat_t                     m_reg;
    sq_t                      sq2_reg;
    logic                     valid2_reg;

    // byte minus 128 is the byte with its top bit flipped
    assign cw = $signed({~in_data.rot_w[ROT_W-1], in_data.rot_w[ROT_W-2:0]});
    assign cx = $signed({~in_data.rot_x[ROT_W-1], in_data.rot_x[ROT_W-2:0]});
    assign cy = $signed({~in_data.rot_y[ROT_W-1], in_data.rot_y[ROT_W-2:0]});
    assign cz = $signed({~in_data.rot_z[ROT_W-1], in_data.rot_z[ROT_W-2:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg     <= PROD_W'(cx) * PROD_W'(cx);
            yy_reg     <= PROD_W'(cy) * PROD_W'(cy);
            zz_reg     <= PROD_W'(cz) * PROD_W'(cz);
            xy_reg     <= PROD_W'(cx) * PROD_W'(cy);
            xz_reg     <= PROD_W'(cx) * PROD_W'(cz);
            yz_reg     <= PROD_W'(cy) * PROD_W'(cz);
            wx_reg     <= PROD_W'(cw) * PROD_W'(cx);
            wy_reg     <= PROD_W'(cw) * PROD_W'(cy);
            wz_reg     <= PROD_W'(cw) * PROD_W'(cz);
            sq1_reg[0] <= SQ_W'(in_data.scale_a) * SQ_W'(in_data.scale_a);
            sq1_reg[1] <= SQ_W'(in_data.scale_b) * SQ_W'(in_data.scale_b);
            sq1_reg[2] <= SQ_W'(in_data.scale_c) * SQ_W'(in_data.scale_c);

            m_reg[0]   <= ONE_Q13 - (MAT_W'(yy_reg) + MAT_W'(zz_reg));
            m_reg[1]   <= MAT_W'(xy_reg) + MAT_W'(wz_reg);
            m_reg[2]   <= MAT_W'(xz_reg) - MAT_W'(wy_reg);
            m_reg[3]   <= MAT_W'(xy_reg) - MAT_W'(wz_reg);
            m_reg[4]   <= ONE_Q13 - (MAT_W'(xx_reg) + MAT_W'(zz_reg));
            m_reg[5]   <= MAT_W'(yz_reg) + MAT_W'(wx_reg);
            m_reg[6]   <= MAT_W'(xz_reg) + MAT_W'(wy_reg);
            m_reg[7]   <= MAT_W'(yz_reg) - MAT_W'(wx_reg);
            m_reg[8]   <= ONE_Q13 - (MAT_W'(xx_reg) + MAT_W'(yy_reg));
            sq2_reg    <= sq1_reg;
        end
    end

    assign valid = valid2_reg;
    assign m     = m_reg;
    assign sq    = sq2_reg;

endmodule

// ===== rtl/scov_mac.sv =====
// ----------------------------------------------------------------------------
// scov_mac
// Three stages: matrix entry products, products times the split scale
// squares, and the sums over the three rows.
// ----------------------------------------------------------------------------
module scov_mac (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  scov_pkg::mat_t m,
    input  scov_pkg::sq_t  sq,
    output logic           valid,
    output scov_pkg::acc_t acc_hi,
    output scov_pkg::acc_t acc_lo
);
    import scov_pkg::*;

    logic signed [P_W-1:0]  p_reg   [N_ENT][N_ROW];
    sq_t                    sq_reg;
    logic                   valid3_reg;

    logic signed [PP_W-1:0] ph_reg  [N_ENT][N_ROW];
    logic signed [PP_W-1:0] pl_reg  [N_ENT][N_ROW];
    logic                   valid4_reg;

    acc_t                   hi_reg;
    acc_t                   lo_reg;
    logic                   valid5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid3_reg <= in_valid;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= sq;
            for (int e = 0; e < N_ENT; e++)
            begin
                for (int k = 0; k < N_ROW; k++)
                begin
                    p_reg[e][k] <= P_W'(m[N_ROW * k + ENT_I[e]])
                                   * P_W'(m[N_ROW * k + ENT_J[e]]);
                    ph_reg[e][k] <= PP_W'(p_reg[e][k])
                                    * PP_W'($signed({1'b0, sq_reg[k][SQ_W-1:HALF_W]}));
                    pl_reg[e][k] <= PP_W'(p_reg[e][k])
                                    * PP_W'($signed({1'b0, sq_reg[k][HALF_W-1:0]}));
                end
                hi_reg[e] <= ACC_W'(ph_reg[e][0]) + ACC_W'(ph_reg[e][1])
                             + ACC_W'(ph_reg[e][2]);
                lo_reg[e] <= ACC_W'(pl_reg[e][0]) + ACC_W'(pl_reg[e][1])
                             + ACC_W'(pl_reg[e][2]);
            end
        end
    end

    assign valid  = valid5_reg;
    assign acc_hi = hi_reg;
    assign acc_lo = lo_reg;

endmodule

// ===== rtl/scov_norm.sv =====
// ----------------------------------------------------------------------------
// scov_norm
// Two stages: join the high and low sums, then floor shift to the output
// fraction and saturate into the output register.
// ----------------------------------------------------------------------------
module scov_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  scov_pkg::acc_t acc_hi,
    input  scov_pkg::acc_t acc_lo,
    output logic           valid,
    output scov_pkg::cov_t cov
);
    import scov_pkg::*;

    localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W-1){1'b0}}};

    logic signed [TOT_W-1:0] tot_reg     [N_ENT];
    logic                    valid6_reg;
    logic signed [TOT_W-1:0] shifted     [N_ENT];
    logic                    fits        [N_ENT];
    cov_t                    cov_next;
    cov_t                    cov_reg;
    logic                    valid7_reg;

    always_comb
    begin
        for (int e = 0; e < N_ENT; e++)
        begin
            shifted[e] = tot_reg[e] >>> SHIFT;
            fits[e]    = (&shifted[e][TOT_W-1:COV_W-1]) || !(|shifted[e][TOT_W-1:COV_W-1]);
            if (fits[e])
            begin
                cov_next[e] = shifted[e][COV_W-1:0];
            end
            else if (shifted[e][TOT_W-1])
            begin
                cov_next[e] = COV_MIN;
            end
            else
            begin
                cov_next[e] = COV_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid6_reg <= 1'b0;
            valid7_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid6_reg <= in_valid;
            valid7_reg <= valid6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < N_ENT; e++)
            begin
                tot_reg[e] <= (TOT_W'(acc_hi[e]) <<< HALF_W) + TOT_W'(acc_lo[e]);
            end
            cov_reg <= cov_next;
        end
    end

    assign valid = valid7_reg;
    assign cov   = cov_reg;

endmodule

// ===== rtl/scov_checker.sv =====
// ----------------------------------------------------------------------------
// scov_checker
// Port-level checks of the covariance core, bound to the top level.
// ----------------------------------------------------------------------------
module scov_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [scov_pkg::OUT_W-1:0] m_axis_tdata
);
    import scov_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // diagonal entries are sums of squares times squares
    a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[COV_W-1] && !m_axis_tdata[4*COV_W-1]
                          && !m_axis_tdata[6*COV_W-1])
        else $error("negative diagonal entry");

    // input side blocks only when the output stalls
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without output stall");

    // held input word drains as soon as the pipeline moves
    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && (!m_axis_tvalid || m_axis_tready) |=> s_axis_tready)
        else $error("skid word not drained");

endmodule

bind splat_covariance_from_rotation_scale_core scov_checker u_scov_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/splat_covariance_from_rotation_scale_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// splat_covariance_from_rotation_scale_core_test
// Checks the splat covariance core over its stream ports. A short table of
// directed splats covers the quaternion byte extremes, the scale extremes and
// a few cases whose covariance is plain diagonal. About 1500 random splats
// follow. Every covariance word is compared with an exact integer model of
// the rotation, scaling and floor-to-fixed-point steps, while both sides
// idle at random, the output holds off for a long stretch and the input
// pauses twice until the pipeline has drained.
// ----------------------------------------------------------------------------
module splat_covariance_from_rotation_scale_core_test;
    import scov_pkg::*;

    typedef struct packed {
        logic signed [COV_W-1:0] cov_22;
        logic signed [COV_W-1:0] cov_12;
        logic signed [COV_W-1:0] cov_11;
        logic signed [COV_W-1:0] cov_02;
        logic signed [COV_W-1:0] cov_01;
        logic signed [COV_W-1:0] cov_00;
    } cov_word_t;

    typedef struct {
        in_word_t  din;
        bit        typed;
        cov_word_t want;
    } splat_row_t;

    localparam int RUN_ITEMS    = 1500;
    localparam int PAUSE_ITEM   = 750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 200;

    localparam logic signed [COV_W-1:0] COV_ONE   = 48'sh0001_0000_0000;
    localparam logic signed [COV_W-1:0] COV_HALF2 = 48'sh0000_4000_0000;
    localparam logic signed [COV_W-1:0] COV_TWO2  = 48'sh0004_0000_0000;
    localparam logic signed [COV_W-1:0] COV_MAXSQ = 48'sh00FF_FFFE_0000;
    localparam logic [SCALE_W-1:0]      SCALE_ONE = 24'h10_0000;
    localparam logic [SCALE_W-1:0]      SCALE_MAX = 24'hFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    cov_word_t  pending_cov[$];
    splat_row_t rows[$];
    cov_word_t  got_cov;
    cov_word_t  want_cov;
    int         fail_count;
    int         results_seen;
    int         cycle_count;

    splat_covariance_from_rotation_scale_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact covariance of one splat, floored to the output fraction and saturated
    function automatic cov_word_t predict_cov(input in_word_t s);
        int                  qw, qx, qy, qz;
        int                  rm [9];
        int                  ri [6];
        int                  rj [6];
        logic signed [127:0] sq [3];
        logic signed [127:0] acc;
        logic signed [127:0] prod;
        logic signed [127:0] lim_hi;
        logic signed [127:0] lim_lo;
        logic [OUT_W-1:0]    flat;
        ri = '{0, 0, 0, 1, 1, 2};
        rj = '{0, 1, 2, 1, 2, 2};
        qw = int'(s.rot_w) - 128;
        qx = int'(s.rot_x) - 128;
        qy = int'(s.rot_y) - 128;
        qz = int'(s.rot_z) - 128;
        rm[0] = 8192 - (qy * qy + qz * qz);
        rm[1] = qx * qy + qw * qz;
        rm[2] = qx * qz - qw * qy;
        rm[3] = qx * qy - qw * qz;
        rm[4] = 8192 - (qx * qx + qz * qz);
        rm[5] = qy * qz + qw * qx;
        rm[6] = qx * qz + qw * qy;
        rm[7] = qy * qz - qw * qx;
        rm[8] = 8192 - (qx * qx + qy * qy);
        sq[0] = {104'd0, s.scale_a} * {104'd0, s.scale_a};
        sq[1] = {104'd0, s.scale_b} * {104'd0, s.scale_b};
        sq[2] = {104'd0, s.scale_c} * {104'd0, s.scale_c};
        lim_hi = (128'sd1 <<< (COV_W - 1)) - 128'sd1;
        lim_lo = -(128'sd1 <<< (COV_W - 1));
        flat = '0;
        for (int e = 0; e < N_ENT; e++)
        begin
            acc = '0;
            for (int k = 0; k < N_ROW; k++)
            begin
                prod = rm[3 * k + ri[e]];
                prod = prod * rm[3 * k + rj[e]];
                acc  = acc + prod * sq[k];
            end
            acc = acc >>> SHIFT;
            if (acc > lim_hi)
                acc = lim_hi;
            else if (acc < lim_lo)
                acc = lim_lo;
            flat[e * COV_W +: COV_W] = acc[COV_W-1:0];
        end
        return cov_word_t'(flat);
    endfunction

    function automatic in_word_t make_splat(input logic [7:0] w, input logic [7:0] x,
                                            input logic [7:0] y, input logic [7:0] z,
                                            input logic [SCALE_W-1:0] a,
                                            input logic [SCALE_W-1:0] b,
                                            input logic [SCALE_W-1:0] c);
        in_word_t s;
        s.rot_w   = w;
        s.rot_x   = x;
        s.rot_y   = y;
        s.rot_z   = z;
        s.scale_a = a;
        s.scale_b = b;
        s.scale_c = c;
        return s;
    endfunction

    function automatic cov_word_t diag_cov(input logic signed [COV_W-1:0] d0,
                                           input logic signed [COV_W-1:0] d1,
                                           input logic signed [COV_W-1:0] d2);
        cov_word_t r;
        r = '0;
        r.cov_00 = d0;
        r.cov_11 = d1;
        r.cov_22 = d2;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_rot();
        logic [7:0] edges [7];
        edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 99) < 15)
            return edges[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return SCALE_MAX;
        else if (r < 26)
            return SCALE_W'($urandom_range(0, 255));
        else if (r < 46)
            return SCALE_W'($urandom_range(32'h8_0000, 32'h20_0000));
        return SCALE_W'($urandom());
    endfunction

    task automatic add_row(input in_word_t din, input bit typed, input cov_word_t want);
        rows.insert(rows.size(), '{din, typed, want});
    endtask

    task automatic send_splat(input in_word_t din, input bit typed, input cov_word_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= din;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_cov.insert(pending_cov.size(), typed ? want : predict_cov(din));
        @(negedge clk);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_cov.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_cov = m_axis_tdata;
            results_seen++;
            if (pending_cov.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected covariance word %h", got_cov);
            end
            else
            begin
                want_cov = pending_cov.pop_front();
                if (got_cov !== want_cov)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("word %0d expected %0d %0d %0d %0d %0d %0d", results_seen,
                                 want_cov.cov_00, want_cov.cov_01, want_cov.cov_02,
                                 want_cov.cov_11, want_cov.cov_12, want_cov.cov_22);
                        $display("word %0d actual   %0d %0d %0d %0d %0d %0d", results_seen,
                                 got_cov.cov_00, got_cov.cov_01, got_cov.cov_02,
                                 got_cov.cov_11, got_cov.cov_12, got_cov.cov_22);
                    end
                end
            end
        end
    end

    // output side: random stalls, free-running windows, one long hold-off
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        int  g;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ((cycle_count % 1000) < 150)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                g = gap_len();
                if (g == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    stall_left = g - 1;
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // input side and end of run
    initial
    begin
        in_word_t   din;
        cov_word_t  none;
        none          = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // identity rotations give a diagonal covariance of the squared scales
        add_row(make_splat(8'd128, 8'd128, 8'd128, 8'd128, '0, '0, '0),
                1'b1, diag_cov('0, '0, '0));
        add_row(make_splat(8'd0, 8'd128, 8'd128, 8'd128, SCALE_ONE, SCALE_ONE, SCALE_ONE),
                1'b1, diag_cov(COV_ONE, COV_ONE, COV_ONE));
        add_row(make_splat(8'd255, 8'd128, 8'd128, 8'd128,
                           SCALE_ONE, 24'h08_0000, 24'h20_0000),
                1'b1, diag_cov(COV_ONE, COV_HALF2, COV_TWO2));
        add_row(make_splat(8'd128, 8'd128, 8'd128, 8'd128, SCALE_MAX, SCALE_MAX, SCALE_MAX),
                1'b1, diag_cov(COV_MAXSQ, COV_MAXSQ, COV_MAXSQ));
        add_row(make_splat(8'd0, 8'd0, 8'd0, 8'd0, SCALE_ONE, SCALE_ONE, SCALE_ONE),
                1'b0, none);
        add_row(make_splat(8'd255, 8'd255, 8'd255, 8'd255, SCALE_MAX, SCALE_MAX, SCALE_MAX),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd0, 8'd128, 8'd128, SCALE_ONE, 24'h20_0000, 24'h08_0000),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd128, 8'd0, 8'd128, SCALE_ONE, 24'h20_0000, 24'h08_0000),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd128, 8'd128, 8'd0, SCALE_ONE, 24'h20_0000, 24'h08_0000),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd255, 8'd128, 8'd128, SCALE_MAX, SCALE_ONE, 24'd1),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd128, 8'd255, 8'd128, SCALE_MAX, SCALE_ONE, 24'd1),
                1'b0, none);
        add_row(make_splat(8'd128, 8'd128, 8'd128, 8'd255, SCALE_MAX, SCALE_ONE, 24'd1),
                1'b0, none);
        add_row(make_splat(8'd0, 8'd255, 8'd0, 8'd255, SCALE_MAX, '0, SCALE_MAX),
                1'b0, none);
        add_row(make_splat(8'd255, 8'd0, 8'd255, 8'd0, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA),
                1'b0, none);
        add_row(make_splat(8'd218, 8'd218, 8'd128, 8'd128, SCALE_ONE, 24'h20_0000, 24'h08_0000),
                1'b0, none);
        add_row(make_splat(8'd1, 8'd254, 8'd2, 8'd253, 24'd1, 24'd2, 24'd3),
                1'b0, none);
        add_row(make_splat(8'h5A, 8'hA5, 8'h3C, 8'hC3, 24'h12_3456, 24'hFE_DCBA, 24'h0F_0F0F),
                1'b0, none);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_splat(rows[i].din, rows[i].typed, rows[i].want);
            idle_sender(gap_len());
        end
        wait_drained();

        for (int n = 0; n < RUN_ITEMS; n++)
        begin
            if (n == PAUSE_ITEM)
                wait_drained();
            din = make_splat(rand_rot(), rand_rot(), rand_rot(), rand_rot(),
                             rand_scale(), rand_scale(), rand_scale());
            send_splat(din, 1'b0, none);
            if ((n % 400) >= 80)
                idle_sender(gap_len());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_cov.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_cov.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
